>>> rtl/core/lrr_pkg.sv
// Shared constants, types and helpers for the ranged Lehmer-style random core.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package lrr_pkg;

  localparam logic [31:0] LCG_INCREMENT = 32'he120fc15;
  localparam logic [31:0] MIX_MULT_A    = 32'h4a39b70d;
  localparam logic [31:0] MIX_MULT_B    = 32'h12fad5c9;
  localparam logic [31:0] COUNTER_RESET = 32'd7564638;

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // one remainder bit per step
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [31:0] ctr;
    logic [31:0] lo;
    logic [31:0] span;
    logic        zero;
  } lrr_item_t;

  typedef struct packed {
    logic [QUEUE_AW:0] count;
    logic              empty;
    logic              full;
  } lrr_qstat_t;

  typedef struct packed {
    logic idle;
    logic dividing;
  } lrr_bstat_t;

  // fold high word of a 64-bit product into the low word
  function automatic logic [31:0] fold64(input logic [63:0] p);
    return p[63:32] ^ p[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lehmer32_ranged_random_core.sv
// Ranged 32-bit random core: front end, two-entry request queue, back end.
// A nonzero span runs the back end through pop, two multiply-fold rounds, the bit-serial
// modulo loop (32 steps) and output load; a zero span skips the loop. The back end takes
// a new request from the queue only when idle, so it handles one transaction at a time.
// Reset (rst_n, synchronous): counter to 7564638, queue empty, back end idle, no result.
// Depends on lrr_pkg, lrr_front, lrr_queue, lrr_back.
`default_nettype none

module lehmer32_ranged_random_core import lrr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic        [31:0]      out_raw_word,
  output logic signed [31:0]      out_ranged_value,
  output logic                    out_span_zero
);

  logic       push_valid, push_ready, pop_valid, pop_ready;
  lrr_item_t  push_item, pop_item;
  lrr_qstat_t q_stat;
  lrr_bstat_t b_stat;

  lrr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_item     (push_item)
  );

  lrr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .stat       (q_stat)
  );

  lrr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_valid        (pop_valid),
    .pop_ready        (pop_ready),
    .pop_item         (pop_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_raw_word     (out_raw_word),
    .out_ranged_value (out_ranged_value),
    .out_span_zero    (out_span_zero),
    .stat             (b_stat)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("request queue over depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !q_stat.full)
    else $error("transaction accepted into full queue");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> !b_stat.idle && !b_stat.dividing)
    else $error("back end popped while busy");

endmodule

`default_nettype wire

>>> rtl/core/lrr_front.sv
// Front end: accepts requests, advances the generator counter, classifies the span.
// Depends on lrr_pkg; feeds lrr_queue.
`default_nettype none

module lrr_front import lrr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output lrr_item_t               push_item
);

  logic [31:0] ctr_r, ctr_nxt;
  logic [31:0] ctr_adv;
  logic [31:0] span;

  assign ctr_adv    = ctr_r + LCG_INCREMENT;
  assign span       = 32'(in_range_high) - 32'(in_range_low);
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_item.ctr  = ctr_adv;
    push_item.lo   = 32'(in_range_low);
    push_item.span = span;
    push_item.zero = (span == 32'd0);
  end

  assign ctr_nxt = (in_valid && push_ready) ? ctr_adv : ctr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r <= COUNTER_RESET;
    end else begin
      ctr_r <= ctr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lrr_queue.sv
// Short FIFO of classified requests between front and back.
// Depends on lrr_pkg.
`default_nettype none

module lrr_queue import lrr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push_valid,
  output logic            push_ready,
  input  wire lrr_item_t  push_item,
  output logic            pop_valid,
  input  wire logic       pop_ready,
  output lrr_item_t       pop_item,
  output lrr_qstat_t      stat
);

  lrr_item_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r, count_nxt;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  assign stat.count = count_r;
  assign stat.empty = !pop_valid;
  assign stat.full  = !push_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lrr_back.sv
// Back end: two registered multiply-fold rounds, restoring modulo by the span,
// output register. Depends on lrr_pkg; drains lrr_queue.
`default_nettype none

module lrr_back import lrr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire lrr_item_t          pop_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic        [31:0]      out_raw_word,
  output logic signed [31:0]      out_ranged_value,
  output logic                    out_span_zero,
  output lrr_bstat_t              stat
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MIX1 = 5'b00010,
    B_MIX2 = 5'b00100,
    B_DIV  = 5'b01000,
    B_DONE = 5'b10000
  } lrr_bstate_t;

  lrr_bstate_t       state_r, state_nxt;
  logic [31:0]       mix_r, lo_r, span_r, raw_r, dvd_r, rem_r;
  logic              zero_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              out_valid_r;
  logic [31:0]       out_raw_r, out_ranged_r;
  logic              out_zero_r;

  logic [63:0]       prod;
  logic [32:0]       trial;
  logic              fits;
  logic              out_load;

  assign pop_ready = (state_r == B_IDLE);
  assign out_load  = (state_r == B_DONE) && (!out_valid_r || out_ready);

  // one multiplier, shared by both mix rounds
  assign prod  = {32'd0, mix_r} * {32'd0, (state_r == B_MIX1) ? MIX_MULT_A : MIX_MULT_B};
  assign trial = {rem_r, dvd_r[31]};
  assign fits  = (trial >= {1'b0, span_r});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (pop_valid) state_nxt = B_MIX1;
      B_MIX1: state_nxt = B_MIX2;
      B_MIX2: state_nxt = zero_r ? B_DONE : B_DIV;
      B_DIV:  if (cnt_r == DIV_CW'(DIV_STEPS-1)) state_nxt = B_DONE;
      B_DONE: if (out_load) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        mix_r  <= pop_item.ctr;
        lo_r   <= pop_item.lo;
        span_r <= pop_item.span;
        zero_r <= pop_item.zero;
      end
      B_MIX1: mix_r <= fold64(prod);
      B_MIX2: begin
        raw_r <= fold64(prod);
        dvd_r <= fold64(prod);
        rem_r <= '0;
        cnt_r <= '0;
      end
      B_DIV: begin
        rem_r <= fits ? 32'(trial - {1'b0, span_r}) : trial[31:0];
        dvd_r <= {dvd_r[30:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_raw_r    <= raw_r;
      out_ranged_r <= zero_r ? lo_r : rem_r + lo_r;
      out_zero_r   <= zero_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_raw_word     = out_raw_r;
  assign out_ranged_value = out_ranged_r;
  assign out_span_zero    = out_zero_r;
  assign stat.idle        = (state_r == B_IDLE);
  assign stat.dividing    = (state_r == B_DIV);

endmodule

`default_nettype wire
